// File: design/agh_pkg.sv
// ----------------------------------------------------------------------------
// agh_pkg: shared types and constants of the audio timeline gap healer
// Conversion constants, register indexes, state encodings and the result
// record passed from the core to the output buffer.
// ----------------------------------------------------------------------------
package agh_pkg;

  localparam int unsigned DRIFT_FRAC_BITS = 16;

  localparam logic [29:0] NS_PER_S  = 30'd1_000_000_000;
  localparam logic [29:0] PPM_SCALE = 30'd1_000_000;
  localparam logic [62:0] MAX63     = {63{1'b1}};

  localparam int unsigned MUL_STEPS = 64;
  localparam int unsigned DIV_BITS  = 94;
  localparam int unsigned CNT_W     = 7;

  localparam logic [1:0] CFG_SAMPLE_RATE = 2'd0;
  localparam logic [1:0] CFG_JITTER_TOL  = 2'd1;
  localparam logic [1:0] CFG_MAX_GAP     = 2'd2;
  localparam logic [1:0] CFG_DRIFT_WIN   = 2'd3;

  typedef enum logic [1:0] {
    MD_IDLE,
    MD_MUL,
    MD_DIV
  } md_phase_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EXP_WAIT,
    ST_CLASS,
    ST_DEC,
    ST_SIL_WAIT,
    ST_FRAME,
    ST_E_WAIT,
    ST_E_DONE,
    ST_MAG,
    ST_DR_WAIT,
    ST_ADD,
    ST_PUSH_SIL,
    ST_PUSH_FRM
  } core_state_e;

  typedef struct packed {
    logic [18:0] sample_rate;
    logic [29:0] jitter_tol;
    logic [33:0] max_gap;
    logic [31:0] drift_win;
  } cfg_t;

  typedef struct packed {
    logic        start;
    logic [63:0] a;
    logic [29:0] b;
    logic [62:0] d;
    logic        ext;
  } md_req_t;

  typedef struct packed {
    logic        done;
    logic [62:0] q;
    logic        ovf;
  } md_rsp_t;

  typedef struct packed {
    logic        is_silence;
    logic [31:0] seq;
    logic [62:0] time_ns;
    logic [23:0] samples;
    logic        gap_flag;
    logic        last;
    logic [31:0] drift;
    logic        drift_ok;
    logic [31:0] healed;
    logic [31:0] truncated;
    logic [31:0] overlaps;
    logic [47:0] silence_total;
  } item_t;

  function automatic logic [31:0] sat_inc32(input logic [31:0] v);
    sat_inc32 = (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  function automatic logic [63:0] sat_add64(input logic [63:0] v, input logic [23:0] n);
    logic [64:0] s;
    s = {1'b0, v} + {41'd0, n};
    sat_add64 = s[64] ? {64{1'b1}} : s[63:0];
  endfunction

endpackage

// File: design/agh_muldiv.sv
// ----------------------------------------------------------------------------
// agh_muldiv: bit-serial multiply then divide unit
// Computes floor(a * b * 2^s / d) with s zero or the drift fraction bits,
// one multiplier bit and then one dividend bit per cycle.
// ----------------------------------------------------------------------------
module agh_muldiv import agh_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  md_req_t req_i,
  output md_rsp_t rsp_o
);

  md_phase_e        ph_q, ph_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [63:0]      a_q, a_d;
  logic [29:0]      b_q, b_d;
  logic [62:0]      d_q, d_d;
  logic             ext_q, ext_d;
  logic [94:0]      acc_q, acc_d;
  logic [62:0]      rem_q, rem_d;
  logic [62:0]      quo_q, quo_d;
  logic             ovf_q, ovf_d;
  logic             done_q, done_d;
  logic [30:0]      sum;
  logic [63:0]      rem_s, diff;
  logic             ge;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q   <= MD_IDLE;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      ph_q   <= ph_d;
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    b_q   <= b_d;
    d_q   <= d_d;
    ext_q <= ext_d;
    acc_q <= acc_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    ovf_q <= ovf_d;
  end

  always_comb begin
    ph_d   = ph_q;
    cnt_d  = cnt_q;
    a_d    = a_q;
    b_d    = b_q;
    d_d    = d_q;
    ext_d  = ext_q;
    acc_d  = acc_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    ovf_d  = ovf_q;
    done_d = 1'b0;
    sum    = acc_q[94:64] + (a_q[0] ? {1'b0, b_q} : 31'd0);
    rem_s  = {rem_q, acc_q[93]};
    diff   = rem_s - {1'b0, d_q};
    ge     = rem_s >= {1'b0, d_q};
    unique case (ph_q)
      MD_IDLE: begin
        if (req_i.start) begin
          a_d   = req_i.a;
          b_d   = req_i.b;
          d_d   = req_i.d;
          ext_d = req_i.ext;
          acc_d = '0;
          rem_d = '0;
          quo_d = '0;
          ovf_d = 1'b0;
          cnt_d = CNT_W'(MUL_STEPS - 1);
          ph_d  = MD_MUL;
        end
      end
      MD_MUL: begin
        acc_d = {1'b0, sum, acc_q[63:1]};
        a_d   = {1'b0, a_q[63:1]};
        if (cnt_q == '0) begin
          ph_d  = MD_DIV;
          cnt_d = ext_q ? CNT_W'(DIV_BITS + DRIFT_FRAC_BITS - 1) : CNT_W'(DIV_BITS - 1);
        end else begin
          cnt_d = cnt_q - CNT_W'(1);
        end
      end
      MD_DIV: begin
        acc_d = {acc_q[93:0], 1'b0};
        rem_d = ge ? diff[62:0] : rem_s[62:0];
        quo_d = {quo_q[61:0], ge};
        ovf_d = ovf_q | quo_q[62];
        if (cnt_q == '0) begin
          ph_d   = MD_IDLE;
          done_d = 1'b1;
        end else begin
          cnt_d = cnt_q - CNT_W'(1);
        end
      end
      default: ph_d = MD_IDLE;
    endcase
  end

  assign rsp_o.done = done_q;
  assign rsp_o.q    = quo_q;
  assign rsp_o.ovf  = ovf_q;

endmodule

// File: design/agh_core.sv
// ----------------------------------------------------------------------------
// agh_core: timeline sequencer of the gap healer
// Holds the anchor, drift and counter state, drives the serial unit through
// the conversions of one frame and pushes its results to the output buffer.
// ----------------------------------------------------------------------------
module agh_core import agh_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [62:0] start_time_ns_i,
  input  logic [15:0] frame_samples_i,
  input  logic        gap_flag_in_i,
  output logic        push_o,
  output item_t       item_o,
  input  logic        space_i
);

  core_state_e st_q, st_d;
  logic        anchored_q, anchored_d;
  logic [62:0] anchor_q, anchor_d;
  logic [63:0] ssa_q, ssa_d;
  logic [62:0] dref_t_q, dref_t_d;
  logic [63:0] dref_s_q, dref_s_d;
  logic [31:0] seq_q, seq_d;
  logic [31:0] drift_q, drift_d;
  logic        drift_ok_q, drift_ok_d;
  logic [31:0] healed_q, healed_d;
  logic [31:0] trunc_cnt_q, trunc_cnt_d;
  logic [31:0] overlap_q, overlap_d;
  logic [47:0] sil_tot_q, sil_tot_d;

  logic [62:0] t_q, t_d;
  logic [15:0] fs_q, fs_d;
  logic        flag_q, flag_d;
  logic [62:0] exp_q, exp_d;
  logic [62:0] dmag_q, dmag_d;
  logic        late_q, late_d;
  logic        trunc_q, trunc_d;
  logic        sil_pend_q, sil_pend_d;
  logic [31:0] sil_seq_q, sil_seq_d;
  logic [23:0] sil_n_q, sil_n_d;
  logic [31:0] frm_seq_q, frm_seq_d;
  logic [62:0] e_q, e_d;
  logic [62:0] mm_q, mm_d;
  logic        mneg_q, mneg_d;
  logic        dneg_q, dneg_d;

  md_req_t     md_req;
  md_rsp_t     md_rsp;
  logic [18:0] rate;
  logic [63:0] exp_sum;
  logic [62:0] ns_sat;
  logic [63:0] s_diff;
  logic [63:0] mag;
  logic        mag_neg;
  logic [48:0] tot_sum;
  logic        qbig;

  agh_muldiv u_muldiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (md_req),
    .rsp_o  (md_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      anchored_q  <= 1'b0;
      anchor_q    <= '0;
      ssa_q       <= '0;
      dref_t_q    <= '0;
      dref_s_q    <= '0;
      seq_q       <= '0;
      drift_q     <= '0;
      drift_ok_q  <= 1'b0;
      healed_q    <= '0;
      trunc_cnt_q <= '0;
      overlap_q   <= '0;
      sil_tot_q   <= '0;
      sil_pend_q  <= 1'b0;
    end else begin
      st_q        <= st_d;
      anchored_q  <= anchored_d;
      anchor_q    <= anchor_d;
      ssa_q       <= ssa_d;
      dref_t_q    <= dref_t_d;
      dref_s_q    <= dref_s_d;
      seq_q       <= seq_d;
      drift_q     <= drift_d;
      drift_ok_q  <= drift_ok_d;
      healed_q    <= healed_d;
      trunc_cnt_q <= trunc_cnt_d;
      overlap_q   <= overlap_d;
      sil_tot_q   <= sil_tot_d;
      sil_pend_q  <= sil_pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    t_q       <= t_d;
    fs_q      <= fs_d;
    flag_q    <= flag_d;
    exp_q     <= exp_d;
    dmag_q    <= dmag_d;
    late_q    <= late_d;
    trunc_q   <= trunc_d;
    sil_seq_q <= sil_seq_d;
    sil_n_q   <= sil_n_d;
    frm_seq_q <= frm_seq_d;
    e_q       <= e_d;
    mm_q      <= mm_d;
    mneg_q    <= mneg_d;
    dneg_q    <= dneg_d;
  end

  assign rate   = (cfg_i.sample_rate == '0) ? 19'd1 : cfg_i.sample_rate;
  assign ns_sat = md_rsp.ovf ? MAX63 : md_rsp.q;

  always_comb begin
    st_d        = st_q;
    anchored_d  = anchored_q;
    anchor_d    = anchor_q;
    ssa_d       = ssa_q;
    dref_t_d    = dref_t_q;
    dref_s_d    = dref_s_q;
    seq_d       = seq_q;
    drift_d     = drift_q;
    drift_ok_d  = drift_ok_q;
    healed_d    = healed_q;
    trunc_cnt_d = trunc_cnt_q;
    overlap_d   = overlap_q;
    sil_tot_d   = sil_tot_q;
    sil_pend_d  = sil_pend_q;
    t_d         = t_q;
    fs_d        = fs_q;
    flag_d      = flag_q;
    exp_d       = exp_q;
    dmag_d      = dmag_q;
    late_d      = late_q;
    trunc_d     = trunc_q;
    sil_seq_d   = sil_seq_q;
    sil_n_d     = sil_n_q;
    frm_seq_d   = frm_seq_q;
    e_d         = e_q;
    mm_d        = mm_q;
    mneg_d      = mneg_q;
    dneg_d      = dneg_q;
    in_ready_o  = 1'b0;
    push_o      = 1'b0;
    md_req      = '0;
    exp_sum     = {1'b0, anchor_q} + {1'b0, ns_sat};
    s_diff      = ssa_q - dref_s_q;
    tot_sum     = {1'b0, sil_tot_q} + {25'd0, md_rsp.q[23:0]};
    qbig        = md_rsp.ovf | (md_rsp.q[62:31] != '0);
    mag         = '0;
    mag_neg     = 1'b1;
    if (mneg_q) begin
      mag = {1'b0, mm_q} + {1'b0, e_q};
    end else if (mm_q >= e_q) begin
      mag     = {1'b0, mm_q - e_q};
      mag_neg = 1'b0;
    end else begin
      mag = {1'b0, e_q - mm_q};
    end

    item_o.is_silence    = 1'b0;
    item_o.seq           = frm_seq_q;
    item_o.time_ns       = t_q;
    item_o.samples       = {8'd0, fs_q};
    item_o.gap_flag      = flag_q;
    item_o.last          = 1'b1;
    item_o.drift         = drift_q;
    item_o.drift_ok      = drift_ok_q;
    item_o.healed        = healed_q;
    item_o.truncated     = trunc_cnt_q;
    item_o.overlaps      = overlap_q;
    item_o.silence_total = sil_tot_q;

    unique case (st_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        sil_pend_d = 1'b0;
        if (in_valid_i) begin
          t_d    = start_time_ns_i;
          fs_d   = frame_samples_i;
          flag_d = gap_flag_in_i;
          if (anchored_q) begin
            md_req.start = 1'b1;
            md_req.a     = ssa_q;
            md_req.b     = NS_PER_S;
            md_req.d     = {44'd0, rate};
            st_d         = ST_EXP_WAIT;
          end else begin
            anchored_d = 1'b1;
            anchor_d   = start_time_ns_i;
            ssa_d      = '0;
            dref_t_d   = start_time_ns_i;
            dref_s_d   = '0;
            st_d       = ST_FRAME;
          end
        end
      end
      ST_EXP_WAIT: begin
        if (md_rsp.done) begin
          exp_d = exp_sum[63] ? MAX63 : exp_sum[62:0];
          st_d  = ST_CLASS;
        end
      end
      ST_CLASS: begin
        late_d = t_q > exp_q;
        dmag_d = (t_q > exp_q) ? t_q - exp_q : exp_q - t_q;
        st_d   = ST_DEC;
      end
      ST_DEC: begin
        st_d = ST_FRAME;
        if (late_q && ((dmag_q > {33'd0, cfg_i.jitter_tol}) || flag_q)) begin
          trunc_d      = dmag_q > {29'd0, cfg_i.max_gap};
          md_req.start = 1'b1;
          md_req.a     = (dmag_q > {29'd0, cfg_i.max_gap}) ? {30'd0, cfg_i.max_gap}
                                                          : {1'b0, dmag_q};
          md_req.b     = {11'd0, rate};
          md_req.d     = {33'd0, NS_PER_S};
          st_d         = ST_SIL_WAIT;
        end else if (!late_q && (dmag_q > {33'd0, cfg_i.jitter_tol})) begin
          overlap_d  = sat_inc32(overlap_q);
          anchor_d   = t_q;
          ssa_d      = '0;
          dref_t_d   = t_q;
          dref_s_d   = '0;
          flag_d     = 1'b1;
        end
      end
      ST_SIL_WAIT: begin
        if (md_rsp.done) begin
          if (md_rsp.q != '0) begin
            sil_pend_d = 1'b1;
            sil_seq_d  = seq_q;
            sil_n_d    = md_rsp.q[23:0];
            seq_d      = seq_q + 32'd1;
            sil_tot_d  = tot_sum[48] ? {48{1'b1}} : tot_sum[47:0];
            ssa_d      = sat_add64(ssa_q, md_rsp.q[23:0]);
          end
          if (trunc_q) begin
            trunc_cnt_d = sat_inc32(trunc_cnt_q);
            anchor_d    = t_q;
            ssa_d       = '0;
            dref_t_d    = t_q;
            dref_s_d    = '0;
            flag_d      = 1'b1;
          end else begin
            healed_d = sat_inc32(healed_q);
            flag_d   = 1'b0;
          end
          st_d = ST_FRAME;
        end
      end
      ST_FRAME: begin
        frm_seq_d = seq_q;
        seq_d     = seq_q + 32'd1;
        if (s_diff >= {32'd0, cfg_i.drift_win}) begin
          md_req.start = 1'b1;
          md_req.a     = s_diff;
          md_req.b     = NS_PER_S;
          md_req.d     = {44'd0, rate};
          st_d         = ST_E_WAIT;
        end else begin
          st_d = ST_ADD;
        end
      end
      ST_E_WAIT: begin
        if (md_rsp.done) begin
          e_d  = ns_sat;
          st_d = ST_E_DONE;
        end
      end
      ST_E_DONE: begin
        if (e_q == '0) begin
          dref_t_d = t_q;
          dref_s_d = ssa_q;
          st_d     = ST_ADD;
        end else begin
          mneg_d = t_q < dref_t_q;
          mm_d   = (t_q < dref_t_q) ? dref_t_q - t_q : t_q - dref_t_q;
          st_d   = ST_MAG;
        end
      end
      ST_MAG: begin
        dneg_d       = mag_neg;
        md_req.start = 1'b1;
        md_req.a     = mag;
        md_req.b     = PPM_SCALE;
        md_req.d     = e_q;
        md_req.ext   = 1'b1;
        st_d         = ST_DR_WAIT;
      end
      ST_DR_WAIT: begin
        if (md_rsp.done) begin
          if (dneg_q) begin
            drift_d = qbig ? 32'h8000_0000 : 32'd0 - md_rsp.q[31:0];
          end else begin
            drift_d = (qbig || (md_rsp.q[30:0] == {31{1'b1}})) ? 32'h7FFF_FFFF
                                                               : md_rsp.q[31:0];
          end
          drift_ok_d = 1'b1;
          dref_t_d   = t_q;
          dref_s_d   = ssa_q;
          st_d       = ST_ADD;
        end
      end
      ST_ADD: begin
        ssa_d = sat_add64(ssa_q, {8'd0, fs_q});
        st_d  = sil_pend_q ? ST_PUSH_SIL : ST_PUSH_FRM;
      end
      ST_PUSH_SIL: begin
        item_o.is_silence = 1'b1;
        item_o.seq        = sil_seq_q;
        item_o.time_ns    = exp_q;
        item_o.samples    = sil_n_q;
        item_o.gap_flag   = 1'b1;
        item_o.last       = 1'b0;
        if (space_i) begin
          push_o = 1'b1;
          st_d   = ST_PUSH_FRM;
        end
      end
      ST_PUSH_FRM: begin
        if (space_i) begin
          push_o = 1'b1;
          st_d   = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

endmodule

// File: design/agh_obuf.sv
// ----------------------------------------------------------------------------
// agh_obuf: two-entry result buffer
// Decouples the sequencer from the output handshake so that a frame can be
// taken in while earlier results still wait.
// ----------------------------------------------------------------------------
module agh_obuf import agh_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  output logic  space_o,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  output item_t item_o
);

  item_t       ent_q [2];
  logic        wr_q, rd_q;
  logic [1:0]  cnt_q;
  logic        pop;

  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = cnt_q != 2'd0;
  assign space_o     = cnt_q != 2'd2;
  assign item_o      = ent_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) begin
        wr_q <= ~wr_q;
      end
      if (pop) begin
        rd_q <= ~rd_q;
      end
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wr_q] <= item_i;
    end
  end

endmodule

// File: design/audio_timeline_gap_healer.sv
// ----------------------------------------------------------------------------
// audio_timeline_gap_healer: audio frame timeline healer
// Anchors a timeline on incoming frame headers, inserts silence for gaps,
// re-anchors on large gaps and early frames and tracks clock drift.
// ----------------------------------------------------------------------------
// One frame header is processed at a time. The first frame after reset needs
// no conversion, or one when the drift window is zero; later frames need one
// sample-to-time conversion, plus one more when a silence marker is computed
// and two more when a drift window closes, and may wait for buffer room.
// Every conversion runs on one shared bit-serial multiply-divide unit: 64
// multiply steps followed by 94 divide steps (110 for the drift ratio).
// Up to two results wait in a two-entry buffer, so the next frame header is
// taken while results of the previous one are still pending. Configuration
// writes are always accepted and should only be made while the block is idle.
module audio_timeline_gap_healer import agh_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [33:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [62:0]        start_time_ns_i,
  input  logic [15:0]        frame_samples_i,
  input  logic               gap_flag_in_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               is_silence_o,
  output logic [31:0]        out_sequence_o,
  output logic [62:0]        out_time_ns_o,
  output logic [23:0]        out_samples_o,
  output logic               out_gap_flag_o,
  output logic               last_of_run_o,
  output logic signed [31:0] drift_ppm_o,
  output logic               drift_valid_o,
  output logic [31:0]        gaps_healed_o,
  output logic [31:0]        gaps_truncated_o,
  output logic [31:0]        overlaps_seen_o,
  output logic [47:0]        silence_total_o
);

  cfg_t  cfg_q;
  item_t push_item, out_item;
  logic  push, space;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sample_rate <= 19'd48000;
      cfg_q.jitter_tol  <= 30'd2000000;
      cfg_q.max_gap     <= 34'd1000000000;
      cfg_q.drift_win   <= 32'd48000;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_SAMPLE_RATE: cfg_q.sample_rate <= cfg_data_i[18:0];
        CFG_JITTER_TOL:  cfg_q.jitter_tol  <= cfg_data_i[29:0];
        CFG_MAX_GAP:     cfg_q.max_gap     <= cfg_data_i;
        CFG_DRIFT_WIN:   cfg_q.drift_win   <= cfg_data_i[31:0];
        default:         cfg_q             <= cfg_q;
      endcase
    end
  end

  agh_core u_core (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .start_time_ns_i (start_time_ns_i),
    .frame_samples_i (frame_samples_i),
    .gap_flag_in_i   (gap_flag_in_i),
    .push_o          (push),
    .item_o          (push_item),
    .space_i         (space)
  );

  agh_obuf u_obuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .item_i      (push_item),
    .space_o     (space),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .item_o      (out_item)
  );

  assign is_silence_o     = out_item.is_silence;
  assign out_sequence_o   = out_item.seq;
  assign out_time_ns_o    = out_item.time_ns;
  assign out_samples_o    = out_item.samples;
  assign out_gap_flag_o   = out_item.gap_flag;
  assign last_of_run_o    = out_item.last;
  assign drift_ppm_o      = out_item.drift;
  assign drift_valid_o    = out_item.drift_ok;
  assign gaps_healed_o    = out_item.healed;
  assign gaps_truncated_o = out_item.truncated;
  assign overlaps_seen_o  = out_item.overlaps;
  assign silence_total_o  = out_item.silence_total;

endmodule

// File: design/agh_checker.sv
// ----------------------------------------------------------------------------
// agh_checker: port-level checks of the gap healer
// Watches the result channel for sequence continuity, item shape and
// monotonic statistics.
// ----------------------------------------------------------------------------
module agh_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic        is_silence_o,
  input logic [31:0] out_sequence_o,
  input logic [23:0] out_samples_o,
  input logic        out_gap_flag_o,
  input logic        last_of_run_o,
  input logic [31:0] gaps_healed_o,
  input logic [47:0] silence_total_o
);

  logic        seen_q;
  logic [31:0] seq_q, healed_q;
  logic [47:0] tot_q;
  logic        beat;

  assign beat = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q   <= 1'b0;
      seq_q    <= '0;
      healed_q <= '0;
      tot_q    <= '0;
    end else if (beat) begin
      seen_q   <= 1'b1;
      seq_q    <= out_sequence_o;
      healed_q <= gaps_healed_o;
      tot_q    <= silence_total_o;
    end
  end

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_sequence_o))
    else $error("result beat dropped or changed while stalled");

  a_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    beat && seen_q |-> out_sequence_o == seq_q + 32'd1)
    else $error("sequence number skipped");

  a_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (last_of_run_o == !is_silence_o) &&
                    (!is_silence_o || (out_gap_flag_o && out_samples_o != '0)))
    else $error("malformed result beat");

  a_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    beat && seen_q |-> gaps_healed_o >= healed_q && silence_total_o >= tot_q)
    else $error("statistics went backwards");

endmodule

bind audio_timeline_gap_healer agh_checker u_agh_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .is_silence_o    (is_silence_o),
  .out_sequence_o  (out_sequence_o),
  .out_samples_o   (out_samples_o),
  .out_gap_flag_o  (out_gap_flag_o),
  .last_of_run_o   (last_of_run_o),
  .gaps_healed_o   (gaps_healed_o),
  .silence_total_o (silence_total_o)
);

// File: test/tb_audio_timeline_gap_healer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_audio_timeline_gap_healer: self-checking bench of the gap healer
// Frame headers are driven through a directed table and then random runs of
// continuing, late, truncated and early frames under several register settings.
// A bit-accurate timeline model predicts every silence and frame beat.
// ----------------------------------------------------------------------------
module tb_audio_timeline_gap_healer;
  import agh_pkg::*;

  localparam int unsigned STALL_LIMIT = 20000;
  localparam logic [63:0] TOP63 = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] TOP48 = 64'h0000_FFFF_FFFF_FFFF;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [1:0]         cfg_index_i = CFG_SAMPLE_RATE;
  logic [33:0]        cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [62:0]        start_time_ns_i = '0;
  logic [15:0]        frame_samples_i = '0;
  logic               gap_flag_in_i = 1'b0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic               is_silence_o;
  logic [31:0]        out_sequence_o;
  logic [62:0]        out_time_ns_o;
  logic [23:0]        out_samples_o;
  logic               out_gap_flag_o;
  logic               last_of_run_o;
  logic signed [31:0] drift_ppm_o;
  logic               drift_valid_o;
  logic [31:0]        gaps_healed_o;
  logic [31:0]        gaps_truncated_o;
  logic [31:0]        overlaps_seen_o;
  logic [47:0]        silence_total_o;

  audio_timeline_gap_healer DUT (.*);

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // timeline model state
  logic [18:0] r_rate;
  logic [29:0] r_tol;
  logic [33:0] r_gap;
  logic [31:0] r_win;
  bit          anch_valid;
  logic [63:0] anch_t, anch_samples, dref_t, dref_samples, sil_sum;
  logic [31:0] seq_next, drift_q, n_healed, n_trunc, n_overlap;
  bit          drift_seen;

  item_t  pending_beats[$];
  int     last_n;
  bit     last_flag;
  int     errs = 0;
  int     idle_pct = 8;
  int     stall_cnt = 0;

  function automatic logic [63:0] samples_to_ns(logic [63:0] s);
    logic [127:0] p;
    p = {64'd0, s} * 128'd1_000_000_000 / ((r_rate == 0) ? 128'd1 : 128'(r_rate));
    return (p > 128'(TOP63)) ? TOP63 : p[63:0];
  endfunction

  function automatic logic [63:0] ns_to_samples(logic [63:0] d);
    logic [127:0] p;
    p = {64'd0, d} * ((r_rate == 0) ? 128'd1 : 128'(r_rate)) / 128'd1_000_000_000;
    return p[63:0];
  endfunction

  function automatic logic [63:0] timeline_now();
    logic [63:0] e;
    e = anch_t + samples_to_ns(anch_samples);
    return (e > TOP63) ? TOP63 : e;
  endfunction

  function automatic void reanchor(logic [63:0] t);
    anch_valid   = 1'b1;
    anch_t       = t;
    anch_samples = '0;
    dref_t       = t;
    dref_samples = '0;
  endfunction

  function automatic void add_samples(logic [63:0] n);
    anch_samples = (anch_samples > ~n) ? '1 : anch_samples + n;
  endfunction

  function automatic void timeline_reset();
    r_rate = 19'd48000;
    r_tol = 30'd2000000;
    r_gap = 34'd1000000000;
    r_win = 32'd48000;
    anch_valid = 1'b0;
    anch_t = '0; anch_samples = '0; dref_t = '0; dref_samples = '0; sil_sum = '0;
    seq_next = '0; drift_q = '0; n_healed = '0; n_trunc = '0; n_overlap = '0;
    drift_seen = 1'b0;
  endfunction

  function automatic void remeasure_drift(logic [63:0] t);
    logic [63:0]  s, e, mm, mag;
    logic [127:0] q;
    bit           neg;
    s = anch_samples - dref_samples;
    if (s < 64'(r_win)) return;
    e = samples_to_ns(s);
    if (e != 0) begin
      mm = (t >= dref_t) ? t - dref_t : dref_t - t;
      if (t < dref_t) begin
        neg = 1'b1;
        mag = mm + e;
      end else if (mm >= e) begin
        neg = 1'b0;
        mag = mm - e;
      end else begin
        neg = 1'b1;
        mag = e - mm;
      end
      q = {64'd0, mag} * (128'd1_000_000 << DRIFT_FRAC_BITS) / {64'd0, e};
      if (neg) drift_q = (q >= 128'h8000_0000) ? 32'h8000_0000 : -q[31:0];
      else drift_q = (q >= 128'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
      drift_seen = 1'b1;
    end
    dref_t = t;
    dref_samples = anch_samples;
  endfunction

  function automatic void heal_frame(logic [62:0] t63, logic [15:0] fs, logic flag_in);
    item_t       beats[2];
    int          n;
    logic [63:0] t, exp_t, dmag, sil;
    bit          late, trunc, flag;
    t = {1'b0, t63};
    flag = flag_in;
    n = 0;
    if (!anch_valid) begin
      reanchor(t);
    end else begin
      exp_t = timeline_now();
      late = t > exp_t;
      dmag = late ? t - exp_t : exp_t - t;
      if (late && (dmag > 64'(r_tol) || flag)) begin
        trunc = dmag > 64'(r_gap);
        sil = ns_to_samples(trunc ? 64'(r_gap) : dmag);
        if (sil != 0) begin
          beats[0] = '0;
          beats[0].is_silence = 1'b1;
          beats[0].seq = seq_next;
          beats[0].time_ns = exp_t[62:0];
          beats[0].samples = sil[23:0];
          beats[0].gap_flag = 1'b1;
          seq_next++;
          sil_sum = sil_sum + sil;
          if (sil_sum > TOP48) sil_sum = TOP48;
          add_samples(sil);
          n = 1;
        end
        if (trunc) begin
          n_trunc = sat_inc32(n_trunc);
          reanchor(t);
          flag = 1'b1;
        end else begin
          n_healed = sat_inc32(n_healed);
          flag = 1'b0;
        end
      end else if (t < exp_t && dmag > 64'(r_tol)) begin
        n_overlap = sat_inc32(n_overlap);
        reanchor(t);
        flag = 1'b1;
      end
    end
    beats[n] = '0;
    beats[n].seq = seq_next;
    beats[n].time_ns = t63;
    beats[n].samples = {8'd0, fs};
    beats[n].gap_flag = flag;
    beats[n].last = 1'b1;
    seq_next++;
    remeasure_drift(t);
    add_samples(64'(fs));
    n++;
    for (int k = 0; k < n; k++) begin
      beats[k].drift = drift_q;
      beats[k].drift_ok = drift_seen;
      beats[k].healed = n_healed;
      beats[k].truncated = n_trunc;
      beats[k].overlaps = n_overlap;
      beats[k].silence_total = sil_sum[47:0];
      pending_beats.insert(pending_beats.size(), beats[k]);
    end
    last_n = n;
    last_flag = flag;
  endfunction

  function automatic void note_mismatch(string what, item_t want, item_t got);
    errs++;
    if (errs <= 10)
      $display("%s: expected %h, got %h", what, want, got);
  endfunction

  // monitor and model update
  always @(posedge clk_i) begin
    item_t got, want;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_SAMPLE_RATE: r_rate = cfg_data_i[18:0];
          CFG_JITTER_TOL:  r_tol = cfg_data_i[29:0];
          CFG_MAX_GAP:     r_gap = cfg_data_i;
          CFG_DRIFT_WIN:   r_win = cfg_data_i[31:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_o)
        heal_frame(start_time_ns_i, frame_samples_i, gap_flag_in_i);
      if (out_valid_o && out_ready_i) begin
        got = '{is_silence_o, out_sequence_o, out_time_ns_o, out_samples_o, out_gap_flag_o,
                last_of_run_o, drift_ppm_o, drift_valid_o, gaps_healed_o, gaps_truncated_o,
                overlaps_seen_o, silence_total_o};
        if (pending_beats.size() == 0) begin
          note_mismatch("unexpected beat", '0, got);
        end else begin
          want = pending_beats.pop_front();
          if (got.is_silence !== want.is_silence || got.seq !== want.seq ||
              got.time_ns !== want.time_ns || got.samples !== want.samples ||
              got.gap_flag !== want.gap_flag || got.last !== want.last ||
              got.drift !== want.drift || got.drift_ok !== want.drift_ok ||
              got.healed !== want.healed || got.truncated !== want.truncated ||
              got.overlaps !== want.overlaps || got.silence_total !== want.silence_total)
            note_mismatch("beat mismatch", want, got);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o))
      stall_cnt <= 0;
    else
      stall_cnt <= stall_cnt + 1;
    if (stall_cnt >= STALL_LIMIT) begin
      $display("audio_timeline_gap_healer: mismatch");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= idle_pct);
  end

  task automatic send_frame(logic [62:0] t, logic [15:0] fs, logic flag);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    start_time_ns_i <= t;
    frame_samples_i <= fs;
    gap_flag_in_i <= flag;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_beats.size() != 0) @(negedge clk_i);
    repeat (800) @(negedge clk_i);
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [33:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic set_regs(logic [33:0] rate, logic [33:0] tol, logic [33:0] gap,
                          logic [33:0] win);
    drain();
    cfg_write(CFG_SAMPLE_RATE, rate);
    cfg_write(CFG_JITTER_TOL, tol);
    cfg_write(CFG_MAX_GAP, gap);
    cfg_write(CFG_DRIFT_WIN, win);
  endtask

  function automatic logic [63:0] rand_upto(logic [63:0] lim);
    logic [63:0] r;
    r = {$urandom, $urandom};
    return (lim == '1) ? r : r % (lim + 1);
  endfunction

  function automatic logic [62:0] offset_time(longint off);
    logic [63:0] e;
    e = timeline_now();
    if (off < 0 && 64'(-off) > e) return '0;
    if (off >= 0 && (e + 64'(off) > TOP63 || e + 64'(off) < e)) return TOP63[62:0];
    return 63'(e + 64'(off));
  endfunction

  task automatic random_frames(int count);
    int          kind;
    longint      off;
    logic [15:0] fs;
    logic        flag;
    logic [62:0] t;
    for (int i = 0; i < count; i++) begin
      kind = $urandom_range(99);
      fs = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(4096, 1));
      if (kind >= 96) fs = $urandom_range(1) ? 16'hFFFF : 16'h0;
      flag = ($urandom_range(9) == 0);
      if (kind < 65) begin
        off = longint'(rand_upto(64'(r_tol) * 2)) - longint'(r_tol);
      end else if (kind < 75) begin
        off = longint'(64'(r_tol) + 1 + rand_upto(r_gap > r_tol ? 64'(r_gap - r_tol) : 0));
      end else if (kind < 80) begin
        off = longint'(64'(r_gap) + 1 + rand_upto(64'd10_000_000_000));
      end else if (kind < 87) begin
        off = -longint'(64'(r_tol) + 1 + rand_upto(64'd100_000_000));
      end else if (kind < 92) begin
        off = longint'(rand_upto(64'd100_000));
        flag = 1'b1;
      end else begin
        off = 0;
      end
      t = (kind >= 92 && kind < 96) ? 63'({$urandom, $urandom}) : offset_time(off);
      send_frame(t, fs, flag);
    end
  endtask

  typedef struct {
    bit          rel;
    longint      off;
    logic [15:0] fs;
    logic        flag;
    int          n_exp;
    bit          flag_exp;
  } dir_row_t;

  dir_row_t dir_rows[12] = '{
    '{1'b0, 1000,                 16'd1024,  1'b0, 1, 1'b0},  // first frame anchors
    '{1'b1, 0,                    16'd1024,  1'b0, 1, 1'b0},
    '{1'b1, 2000000,              16'd0,     1'b0, 1, 1'b0},  // edge of jitter band
    '{1'b1, -1000,                16'hFFFF,  1'b1, 1, 1'b1},  // flag kept in band
    '{1'b1, 1,                    16'd512,   1'b1, 1, 1'b0},  // zero-sample heal
    '{1'b1, 50000000,             16'd1024,  1'b0, 2, 1'b0},  // healed gap
    '{1'b1, 2000000000,           16'd1024,  1'b0, 2, 1'b1},  // truncated gap
    '{1'b1, -5000000,             16'd1024,  1'b0, 1, 1'b1},  // overlap
    '{1'b1, -1000,                16'd1024,  1'b1, 1, 1'b1},
    '{1'b0, 64'h7FFF_FFFF_FFFF_FFFF, 16'hFFFF, 1'b0, 2, 1'b1},
    '{1'b1, 0,                    16'hFFFF,  1'b0, 1, 1'b0},  // saturated timeline
    '{1'b0, 0,                    16'h0,     1'b1, 1, 1'b1}
  };

  initial begin
    timeline_reset();
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[i]) begin
      send_frame(dir_rows[i].rel ? offset_time(dir_rows[i].off) : 63'(dir_rows[i].off),
                 dir_rows[i].fs, dir_rows[i].flag);
      if (last_n != dir_rows[i].n_exp || last_flag != dir_rows[i].flag_exp) begin
        errs++;
        if (errs <= 10)
          $display("row %0d: expected %0d beats flag %0b, model gives %0d flag %0b",
                   i, dir_rows[i].n_exp, dir_rows[i].flag_exp, last_n, last_flag);
      end
    end
    random_frames(300);

    set_regs(34'd1, 34'd0, 34'd0, 34'd0);
    random_frames(200);

    set_regs(34'd384000, 34'h3FFF_FFFF, 34'h3_FFFF_FFFF, 34'hFFFF_FFFF);
    idle_pct = 0;
    random_frames(250);
    idle_pct = 8;

    set_regs(34'h7FFFF, 34'd1000, 34'd5_000_000_000, 34'd0);
    random_frames(100);

    set_regs(34'd0, 34'd1000, 34'd5_000_000_000, 34'd0);
    random_frames(100);

    set_regs(34'd44100, 34'd500000, 34'd10_000_000_000, 34'd4096);
    random_frames(500);

    drain();
    if (errs == 0)
      $display("audio_timeline_gap_healer: match");
    else
      $display("audio_timeline_gap_healer: mismatch");
    $finish;
  end

endmodule

// File: filelist.f
design/agh_pkg.sv
design/agh_muldiv.sv
design/agh_core.sv
design/agh_obuf.sv
design/audio_timeline_gap_healer.sv
design/agh_checker.sv
test/tb_audio_timeline_gap_healer.sv
